// ===== rtl/pbts_pkg.sv =====
// ----------------------------------------------------------------------------
// pbts_pkg
// Shared types, codes and helpers for the priority bitmap task scheduler.
// ----------------------------------------------------------------------------
package pbts_pkg;

    // Command codes carried on the cmd field
    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_DELAY  = 3'd1,
        CMD_LOCK   = 3'd2,
        CMD_UNLOCK = 3'd3,
        CMD_SCHED  = 3'd4,
        CMD_START  = 3'd5
    } cmd_e_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_SCHED,
        ST_PICK,
        ST_FINISH
    } ctl_state_t;

    localparam logic [7:0] LOCK_MAX = 8'd255;
    localparam int unsigned MASK_W  = 32;
    localparam int unsigned PRIO_W  = 5;

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // transaction accepted, clear result flags
        logic tick_begin;  // count tick, arm the delay walk
        logic delay_park;  // park running task with new delay
        logic lock_inc;
        logic lock_dec;
        logic start_init;  // reload ready set, clear delays, lock, ticks
        logic walk_step;   // advance the delay walk
        logic sched;       // schedule if unlocked
        logic start_pick;  // forced pick after start
        logic out_load;    // move result into output register
    } ctl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic lock_zero;
        logic lock_one;
        logic walk_done;
        logic out_free;
    } dp_stat_t;

    typedef struct packed {
        logic              found;
        logic [PRIO_W-1:0] idx;
    } pick_t;

    // Lowest set bit: isolate it, then OR the positions of the one-hot vector.
    function automatic pick_t lowest_set(input logic [MASK_W-1:0] bits);
        logic [MASK_W-1:0] iso;
        pick_t             res;
        iso       = bits & (~bits + {{(MASK_W-1){1'b0}}, 1'b1});
        res.found = |bits;
        res.idx   = '0;
        for (int p = 0; p < MASK_W; p++) begin
            if (iso[p])
            begin
                res.idx = res.idx | PRIO_W'(p);
            end
        end
        return res;
    endfunction

endpackage

// ===== rtl/pbts_ctrl.sv =====
// ----------------------------------------------------------------------------
// pbts_ctrl
// Command sequencer: accepts a transaction, steps the datapath, issues result.
// ----------------------------------------------------------------------------
module pbts_ctrl
    import pbts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] cmd,
    input  dp_stat_t   stat,
    output ctl_cmd_t   dp_cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        dp_cmd     = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    dp_cmd.load = 1'b1;
                    case (cmd_e_t'(cmd))
                        CMD_TICK:
                        begin
                            dp_cmd.tick_begin = 1'b1;
                            state_next        = ST_WALK;
                        end
                        CMD_DELAY:
                        begin
                            dp_cmd.delay_park = 1'b1;
                            state_next        = ST_SCHED;
                        end
                        CMD_LOCK:
                        begin
                            dp_cmd.lock_inc = 1'b1;
                            state_next      = ST_FINISH;
                        end
                        CMD_UNLOCK:
                        begin
                            dp_cmd.lock_dec = !stat.lock_zero;
                            // reaching zero triggers a schedule
                            state_next = (stat.lock_one) ? ST_SCHED : ST_FINISH;
                        end
                        CMD_SCHED:
                        begin
                            state_next = ST_SCHED;
                        end
                        CMD_START:
                        begin
                            dp_cmd.start_init = 1'b1;
                            state_next        = ST_PICK;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                dp_cmd.walk_step = 1'b1;
                if (stat.walk_done)
                begin
                    state_next = ST_SCHED;
                end
            end
            ST_SCHED:
            begin
                dp_cmd.sched = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_PICK:
            begin
                dp_cmd.start_pick = 1'b1;
                state_next        = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    dp_cmd.out_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

// ===== rtl/pbts_datapath.sv =====
// ----------------------------------------------------------------------------
// pbts_datapath
// Ready bitmap, delay counter memory, lock/tick counters and output register.
// ----------------------------------------------------------------------------
module pbts_datapath
    import pbts_pkg::*;
#(
    parameter int unsigned PRIO_COUNT = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctl_cmd_t    dp_cmd,
    output dp_stat_t    stat,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic [15:0] delay_ticks,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        switch_now,
    output logic [4:0]  next_prio,
    output logic        none_ready,
    output logic [7:0]  lock_depth,
    output logic [31:0] ticks_seen
);

    localparam int unsigned IDX_W = (PRIO_COUNT > 1) ? $clog2(PRIO_COUNT) : 1;
    localparam int unsigned CNT_W = $clog2(PRIO_COUNT + 1);
    localparam logic [63:0] VM64  = (64'd1 << PRIO_COUNT) - 64'd1;
    localparam logic [MASK_W-1:0] VALID_MASK = VM64[MASK_W-1:0];
    localparam logic [CNT_W-1:0]  WALK_END   = CNT_W'(PRIO_COUNT);

    // delay counter memory, entries valid only after a write since start/reset
    logic [15:0]           mem [PRIO_COUNT];
    logic [15:0]           mem_rd_reg;
    logic                  mem_we;
    logic                  mem_re;
    logic [IDX_W-1:0]      mem_waddr;
    logic [15:0]           mem_wdata;

    logic [MASK_W-1:0]     present_reg;
    logic [MASK_W-1:0]     ready_reg,      ready_next;
    logic [PRIO_COUNT-1:0] dvalid_reg,     dvalid_next;
    logic [PRIO_W-1:0]     running_reg,    running_next;
    logic [7:0]            lock_reg,       lock_next;
    logic [31:0]           ticks_reg,      ticks_next;
    logic                  sw_reg,         sw_next;
    logic                  none_reg,       none_next;
    logic [CNT_W-1:0]      walk_cnt_reg,   walk_cnt_next;
    logic                  proc_valid_reg, proc_valid_next;
    logic [IDX_W-1:0]      proc_idx_reg,   proc_idx_next;
    logic                  rd_ok_reg,      rd_ok_next;
    logic                  out_valid_reg,  out_valid_next;

    logic [PRIO_W-1:0]     out_prio_reg;
    logic                  out_sw_reg;
    logic                  out_none_reg;
    logic [7:0]            out_lock_reg;
    logic [31:0]           out_ticks_reg;

    logic [IDX_W-1:0]      walk_idx;
    logic [IDX_W-1:0]      run_idx;
    logic [15:0]           cur_delay;
    pick_t                 pick;

    assign walk_idx  = walk_cnt_reg[IDX_W-1:0];
    assign run_idx   = running_reg[IDX_W-1:0];
    assign cur_delay = rd_ok_reg ? mem_rd_reg : 16'd0;
    assign pick      = lowest_set(ready_reg & present_reg & VALID_MASK);
    assign mem_re    = dp_cmd.walk_step && (walk_cnt_reg != WALK_END);

    always_comb
    begin
        ready_next      = ready_reg;
        dvalid_next     = dvalid_reg;
        running_next    = running_reg;
        lock_next       = lock_reg;
        ticks_next      = ticks_reg;
        sw_next         = sw_reg;
        none_next       = none_reg;
        walk_cnt_next   = walk_cnt_reg;
        proc_valid_next = 1'b0;
        proc_idx_next   = proc_idx_reg;
        rd_ok_next      = rd_ok_reg;
        out_valid_next  = out_valid_reg && out_stall;
        mem_we          = 1'b0;
        mem_waddr       = run_idx;
        mem_wdata       = delay_ticks;

        if (dp_cmd.load)
        begin
            sw_next   = 1'b0;
            none_next = 1'b0;
        end

        if (dp_cmd.tick_begin)
        begin
            ticks_next    = ticks_reg + 32'd1;
            walk_cnt_next = '0;
        end

        // walk stage one: read entry walk_idx
        if (mem_re)
        begin
            walk_cnt_next   = walk_cnt_reg + CNT_W'(1);
            proc_valid_next = 1'b1;
            proc_idx_next   = walk_idx;
            rd_ok_next      = dvalid_reg[walk_idx];
        end

        // walk stage two: count down or mark ready
        if (proc_valid_reg && present_reg[proc_idx_reg])
        begin
            if (cur_delay != 16'd0)
            begin
                mem_we    = 1'b1;
                mem_waddr = proc_idx_reg;
                mem_wdata = cur_delay - 16'd1;
            end
            else
            begin
                ready_next[proc_idx_reg] = 1'b1;
            end
        end

        if (dp_cmd.delay_park)
        begin
            mem_we               = 1'b1;
            mem_waddr            = run_idx;
            mem_wdata            = delay_ticks;
            dvalid_next[run_idx] = 1'b1;
            ready_next[run_idx]  = 1'b0;
        end

        if (dp_cmd.lock_inc && (lock_reg != LOCK_MAX))
        begin
            lock_next = lock_reg + 8'd1;
        end

        if (dp_cmd.lock_dec)
        begin
            lock_next = lock_reg - 8'd1;
        end

        if (dp_cmd.start_init)
        begin
            ready_next  = present_reg & VALID_MASK;
            dvalid_next = '0;
            ticks_next  = '0;
            lock_next   = '0;
        end

        if (dp_cmd.sched && (lock_reg == 8'd0))
        begin
            if (!pick.found)
            begin
                none_next = 1'b1;
            end
            else if (pick.idx != running_reg)
            begin
                running_next = pick.idx;
                sw_next      = 1'b1;
            end
        end

        if (dp_cmd.start_pick)
        begin
            if (pick.found)
            begin
                running_next = pick.idx;
                sw_next      = 1'b1;
            end
            else
            begin
                none_next = 1'b1;
            end
        end

        if (dp_cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg    <= '0;
            ready_reg      <= '0;
            dvalid_reg     <= '0;
            running_reg    <= '0;
            lock_reg       <= '0;
            ticks_reg      <= '0;
            sw_reg         <= 1'b0;
            none_reg       <= 1'b0;
            walk_cnt_reg   <= '0;
            proc_valid_reg <= 1'b0;
            proc_idx_reg   <= '0;
            rd_ok_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                present_reg <= cfg_wr_data;
            end
            ready_reg      <= ready_next;
            dvalid_reg     <= dvalid_next;
            running_reg    <= running_next;
            lock_reg       <= lock_next;
            ticks_reg      <= ticks_next;
            sw_reg         <= sw_next;
            none_reg       <= none_next;
            walk_cnt_reg   <= walk_cnt_next;
            proc_valid_reg <= proc_valid_next;
            proc_idx_reg   <= proc_idx_next;
            rd_ok_reg      <= rd_ok_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rd_reg <= mem[walk_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.out_load)
        begin
            out_sw_reg    <= sw_reg;
            out_prio_reg  <= running_reg;
            out_none_reg  <= none_reg;
            out_lock_reg  <= lock_reg;
            out_ticks_reg <= ticks_reg;
        end
    end

    assign stat.lock_zero = (lock_reg == 8'd0);
    assign stat.lock_one  = (lock_reg == 8'd1);
    assign stat.walk_done = (walk_cnt_reg == WALK_END) && !proc_valid_reg;
    assign stat.out_free  = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign switch_now = out_sw_reg;
    assign next_prio  = out_prio_reg;
    assign none_ready = out_none_reg;
    assign lock_depth = out_lock_reg;
    assign ticks_seen = out_ticks_reg;

    // a schedule reports either a switch or an empty set, never both
    a_sw_none: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.out_load |-> !(sw_reg && none_reg))
        else $error("switch and none_ready both set");

    // running task always lies inside the priority range
    a_run_range: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg < PRIO_W'(PRIO_COUNT - 1) || running_reg == PRIO_W'(PRIO_COUNT - 1))
        else $error("running priority out of range");

    // a pending result is never overwritten
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.out_load |-> (!out_valid_reg || !out_stall))
        else $error("result register overrun");

    // start clears lock depth and tick count
    a_start_clear: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.start_init |=> (lock_reg == 8'd0) && (ticks_reg == 32'd0))
        else $error("start did not clear counters");

endmodule

// ===== rtl/priority_bitmap_task_scheduler_top.sv =====
// Sequence: tick counts, walks the delay counters, then schedules; start
//   picks; delay, sched, unlock-to-zero schedule; other commands do neither.
// Throughput: one transaction at a time; the tick walk over the delay counter
//   memory (one entry per cycle, one read and one write port) sets the rate.
// Reset (rst_n, async, active low) clears control state; delay counters read
//   as zero through per-entry valid bits, so there is no clearing pass.
// ----------------------------------------------------------------------------
// priority_bitmap_task_scheduler_top
// One-task-per-priority scheduler with a ready bitmap, per-task tick delays,
// lock nesting and a tick counter. Lowest priority number wins.
// ----------------------------------------------------------------------------
module priority_bitmap_task_scheduler_top
    import pbts_pkg::*;
#(
    parameter int unsigned PRIO_COUNT = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    // present task mask register
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    // command channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  cmd,
    input  logic [15:0] delay_ticks,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        switch_now,
    output logic [4:0]  next_prio,
    output logic        none_ready,
    output logic [7:0]  lock_depth,
    output logic [31:0] ticks_seen
);

    // Controller decodes each command transaction into datapath steps:
    //   tick   -> count, then walk every delay counter (read one / update the
    //             previous one each cycle), then schedule
    //   delay  -> park running task, then schedule
    //   start  -> reload ready set, then forced pick
    //   result -> loaded into the output register once it is free, so the
    //             next command can be accepted while a result waits
    ctl_cmd_t dp_cmd;
    dp_stat_t stat;

    pbts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .stat     (stat),
        .dp_cmd   (dp_cmd)
    );

    pbts_datapath #(
        .PRIO_COUNT (PRIO_COUNT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .dp_cmd      (dp_cmd),
        .stat        (stat),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .delay_ticks (delay_ticks),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .switch_now  (switch_now),
        .next_prio   (next_prio),
        .none_ready  (none_ready),
        .lock_depth  (lock_depth),
        .ticks_seen  (ticks_seen)
    );

endmodule

// ===== tb/sv/sched_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sched_checker
// Watches the command and result channels of the task scheduler, keeps its own
// copy of the scheduler state and compares every result with its prediction.
// ----------------------------------------------------------------------------
module sched_checker
    import pbts_pkg::*;
#(
    parameter int unsigned PRIO_COUNT = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [2:0]  cmd,
    input  logic [15:0] delay_ticks,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        switch_now,
    input  logic [4:0]  next_prio,
    input  logic        none_ready,
    input  logic [7:0]  lock_depth,
    input  logic [31:0] ticks_seen,
    output int          fail_count,
    output int          pending,
    output int          checked,
    output int          switches
);

    typedef struct packed {
        logic        sw;
        logic [4:0]  prio;
        logic        idle;
        logic [7:0]  depth;
        logic [31:0] ticks;
    } sched_outcome_t;

    localparam logic [31:0] PRIO_MASK =
        (PRIO_COUNT >= 32) ? 32'hFFFF_FFFF : ((32'd1 << PRIO_COUNT) - 32'd1);

    logic [31:0]    present_q;
    logic [31:0]    ready_q;
    logic [15:0]    wait_left [PRIO_COUNT];
    logic [4:0]     running_q;
    logic [7:0]     depth_q;
    logic [31:0]    tick_q;
    sched_outcome_t outcome_q [$];

    function automatic logic [4:0] first_ready(input logic [31:0] bits);
        logic [4:0] pick;
        pick = '0;
        for (int p = 31; p >= 0; p--)
        begin
            if (bits[p])
            begin
                pick = p[4:0];
            end
        end
        return pick;
    endfunction

    // schedule point: no effect while locked
    task automatic choose_task(inout logic sw, inout logic idle);
        logic [31:0] cand;
        logic [4:0]  pick;
        cand = ready_q & present_q & PRIO_MASK;
        if (depth_q == 8'd0)
        begin
            if (cand == 32'd0)
            begin
                idle = 1'b1;
            end
            else
            begin
                pick = first_ready(cand);
                if (pick != running_q)
                begin
                    running_q = pick;
                    sw        = 1'b1;
                end
            end
        end
    endtask

    task automatic step_scheduler(input logic [2:0] op, input logic [15:0] dt,
                                  output sched_outcome_t res);
        logic sw;
        logic idle;
        sw   = 1'b0;
        idle = 1'b0;
        case (op)
            CMD_TICK:
            begin
                for (int p = 0; p < PRIO_COUNT; p++)
                begin
                    if (present_q[p])
                    begin
                        if (wait_left[p] != 16'd0)
                            wait_left[p] = wait_left[p] - 16'd1;
                        else
                            ready_q[p] = 1'b1;
                    end
                end
                tick_q = tick_q + 32'd1;
                choose_task(sw, idle);
            end
            CMD_DELAY:
            begin
                if (running_q < PRIO_COUNT)
                begin
                    wait_left[running_q] = dt;
                    ready_q[running_q]   = 1'b0;
                end
                choose_task(sw, idle);
            end
            CMD_LOCK:
            begin
                if (depth_q != LOCK_MAX)
                    depth_q = depth_q + 8'd1;
            end
            CMD_UNLOCK:
            begin
                if (depth_q != 8'd0)
                begin
                    depth_q = depth_q - 8'd1;
                    if (depth_q == 8'd0)
                        choose_task(sw, idle);
                end
            end
            CMD_SCHED:
            begin
                choose_task(sw, idle);
            end
            CMD_START:
            begin
                ready_q = present_q & PRIO_MASK;
                for (int p = 0; p < PRIO_COUNT; p++)
                    wait_left[p] = 16'd0;
                tick_q  = 32'd0;
                depth_q = 8'd0;
                if (ready_q == 32'd0)
                begin
                    idle = 1'b1;
                end
                else
                begin
                    running_q = first_ready(ready_q);
                    sw        = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        res = {sw, running_q, idle, depth_q, tick_q};
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        sched_outcome_t want;
        sched_outcome_t got;
        if (!rst_n)
        begin
            present_q = '0;
            ready_q   = '0;
            running_q = '0;
            depth_q   = '0;
            tick_q    = '0;
            for (int p = 0; p < PRIO_COUNT; p++)
                wait_left[p] = 16'd0;
            outcome_q.delete();
            fail_count = 0;
            pending    = 0;
            checked    = 0;
            switches   = 0;
        end
        else
        begin
            if (cfg_wr_en)
                present_q = cfg_wr_data;
            if (in_valid && !in_stall)
            begin
                step_scheduler(cmd, delay_ticks, want);
                outcome_q.push_back(want);
            end
            if (out_valid && !out_stall)
            begin
                got = {switch_now, next_prio, none_ready, lock_depth, ticks_seen};
                checked++;
                if (got.sw === 1'b1)
                    switches++;
                if (outcome_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result with no command outstanding: sw=%0d prio=%0d",
                                 $realtime, got.sw, got.prio);
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch  expected sw=%0d prio=%0d none=%0d",
                                     $realtime, want.sw, want.prio, want.idle,
                                     " depth=%0d ticks=%0d", want.depth, want.ticks,
                                     "  got sw=%0d prio=%0d none=%0d", got.sw,
                                     got.prio, got.idle, " depth=%0d ticks=%0d",
                                     got.depth, got.ticks);
                    end
                end
            end
            pending = outcome_q.size();
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives scheduler commands and task-mask settings into the priority bitmap
// task scheduler; a checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module testbench
    import pbts_pkg::*;
();

    // Command codes the block must ignore
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    // Longest command is a tick. Settle for longer than a tick takes.
    localparam int SETTLE_CYCLES = 40;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  cmd;
    logic [15:0] delay_ticks;
    logic        out_valid;
    logic        out_stall;
    logic        switch_now;
    logic [4:0]  next_prio;
    logic        none_ready;
    logic [7:0]  lock_depth;
    logic [31:0] ticks_seen;

    int fail_count;
    int pending;
    int checked;
    int switches;

    // Idle rates in percent, changed per phase. Zero means back-to-back.
    int gap_pct;
    int stall_pct;

    int sent_by_cmd [8];
    int mask_writes;
    int total_sent;

    priority_bitmap_task_scheduler_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .delay_ticks (delay_ticks),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .switch_now  (switch_now),
        .next_prio   (next_prio),
        .none_ready  (none_ready),
        .lock_depth  (lock_depth),
        .ticks_seen  (ticks_seen)
    );

    sched_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .delay_ticks (delay_ticks),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .switch_now  (switch_now),
        .next_prio   (next_prio),
        .none_ready  (none_ready),
        .lock_depth  (lock_depth),
        .ticks_seen  (ticks_seen),
        .fail_count  (fail_count),
        .pending     (pending),
        .checked     (checked),
        .switches    (switches)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Watchdog: far beyond the slowest legal run (every transaction a tick
    // with the longest sender gap and receiver stall, plus the lock burst).
    initial
    begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Result side back-pressure: random stall bursts of random length.
    // Payload is never touched here, only out_stall, and only at negedge.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 11)) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    // One command transaction. Entered and left at a falling edge; the
    // transaction is taken at the first rising edge with in_stall low.
    task automatic issue(input logic [2:0] op, input logic [15:0] dt);
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
            repeat ($urandom_range(1, 11)) @(negedge clk);
        in_valid    = 1'b1;
        cmd         = op;
        delay_ticks = dt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
        sent_by_cmd[op]++;
        total_sent++;
    endtask

    // Hold off until every expected result is back, then let a full tick
    // latency pass so the block is surely idle.
    task automatic drain_results;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // The task mask is only changed with the block idle.
    task automatic write_mask(input logic [31:0] mask);
        drain_results();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = mask;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        mask_writes++;
    endtask

    // Mostly a live task set: ticks and delays dominate, lock and unlock
    // roughly balance so the scheduler spends most time unlocked. Delays are
    // short so parked tasks come back; a few use the full 16-bit range.
    task automatic random_item;
        int          r;
        int          d;
        logic [15:0] dt;
        logic [2:0]  op;
        r = $urandom_range(0, 99);
        d = $urandom_range(0, 9);
        if (r < 40)
            op = CMD_TICK;
        else if (r < 60)
            op = CMD_DELAY;
        else if (r < 72)
            op = CMD_SCHED;
        else if (r < 82)
            op = CMD_LOCK;
        else if (r < 94)
            op = CMD_UNLOCK;
        else if (r < 97)
            op = CMD_START;
        else if (r < 99)
            op = CMD_SPARE_6;
        else
            op = CMD_SPARE_7;
        if (op != CMD_DELAY || d == 0)
            dt = 16'($urandom);
        else if (d < 8)
            dt = 16'($urandom_range(0, 4));
        else
            dt = 16'($urandom_range(5, 40));
        issue(op, dt);
    endtask

    // A phase: new task set, a start, then random traffic.
    task automatic run_phase(input logic [31:0] mask, input int count);
        write_mask(mask);
        issue(CMD_START, 16'($urandom));
        repeat (count - 1) random_item();
    endtask

    initial
    begin
        // Every input known from time zero
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        cmd         = CMD_TICK;
        delay_ticks = '0;
        gap_pct     = 0;
        stall_pct   = 0;
        mask_writes = 0;
        total_sent  = 0;
        foreach (sent_by_cmd[i])
            sent_by_cmd[i] = 0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // --- Directed part ---------------------------------------------
        // No task present (mask still at its reset value): start and every
        // schedule find nothing ready; spare codes must do nothing.
        issue(CMD_START, 16'h0000);
        issue(CMD_TICK, 16'hFFFF);
        issue(CMD_SCHED, 16'h0000);
        issue(CMD_DELAY, 16'hFFFF);
        issue(CMD_SPARE_6, 16'h5A5A);
        issue(CMD_SPARE_7, 16'hA5A5);

        // All 32 priorities present
        write_mask(32'hFFFF_FFFF);
        issue(CMD_START, 16'h0000);
        issue(CMD_DELAY, 16'hFFFF);      // park prio 0 for the longest delay
        issue(CMD_DELAY, 16'h0000);      // park prio 1 with zero delay
        issue(CMD_TICK, 16'h0000);       // prio 1 becomes ready again
        issue(CMD_SCHED, 16'h0000);
        issue(CMD_LOCK, 16'h0000);
        issue(CMD_SCHED, 16'h0000);      // locked: no switch, no idle flag
        issue(CMD_TICK, 16'h0000);
        issue(CMD_UNLOCK, 16'h0000);     // back to depth zero: schedules
        issue(CMD_UNLOCK, 16'h0000);     // at depth zero: nothing happens
        issue(CMD_DELAY, 16'h5555);
        issue(CMD_DELAY, 16'hAAAA);
        issue(CMD_TICK, 16'h0000);

        // Only the top priority present. Ready bits of absent tasks are left
        // over from before and must be ignored by the schedule.
        write_mask(32'h8000_0000);
        issue(CMD_SCHED, 16'h0000);
        issue(CMD_START, 16'h0000);
        issue(CMD_DELAY, 16'h0002);      // only task parked: idle flag
        issue(CMD_TICK, 16'h0000);
        issue(CMD_TICK, 16'h0000);
        issue(CMD_TICK, 16'h0000);       // delay has run out: ready again

        // --- Random part -------------------------------------------------
        gap_pct   = 15;
        stall_pct = 15;
        run_phase($urandom, 220);

        // stretch with no idling at all
        gap_pct   = 0;
        stall_pct = 0;
        run_phase(32'hFFFF_FFFF, 220);

        // sparse task set; halfway the sender waits for every result
        gap_pct   = 30;
        stall_pct = 30;
        run_phase($urandom & $urandom & $urandom, 110);
        drain_results();
        repeat (110) random_item();

        gap_pct   = 10;
        stall_pct = 40;
        run_phase(32'h0000_0001, 150);

        gap_pct   = 40;
        stall_pct = 5;
        run_phase(32'h8000_0000, 150);

        // Lock nesting up past saturation, some traffic while saturated,
        // then unwind to zero and one extra unlock at depth zero.
        gap_pct   = 10;
        stall_pct = 10;
        write_mask($urandom | $urandom);
        issue(CMD_START, 16'($urandom));
        repeat (258) issue(CMD_LOCK, 16'($urandom));
        issue(CMD_TICK, 16'($urandom));
        issue(CMD_SCHED, 16'($urandom));
        issue(CMD_DELAY, 16'($urandom_range(0, 4)));
        repeat (256) issue(CMD_UNLOCK, 16'($urandom));

        gap_pct   = 20;
        stall_pct = 20;
        run_phase($urandom, 220);

        // final part without idling on either side
        gap_pct   = 0;
        stall_pct = 0;
        run_phase($urandom | $urandom, 200);

        drain_results();

        $display("Drove %0d commands under %0d task-mask settings: %0d ticks, %0d delays,",
                 total_sent, mask_writes, sent_by_cmd[CMD_TICK], sent_by_cmd[CMD_DELAY]);
        $display("%0d schedules, %0d starts; %0d results compared, %0d with a task switch.",
                 sent_by_cmd[CMD_SCHED], sent_by_cmd[CMD_START], checked, switches);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/pbts_pkg.sv
rtl/pbts_ctrl.sv
rtl/pbts_datapath.sv
rtl/priority_bitmap_task_scheduler_top.sv
tb/sv/sched_checker.sv
tb/sv/testbench.sv
